@@ design/twsel_pkg.sv @@
// Types and constants shared by the transmission window selector.
// No dependencies.
`default_nettype none

package twsel_pkg;

    localparam int TIME_W  = 63;
    localparam int FREQ_W  = 32;
    localparam int BW_W    = 27;
    localparam int RATE_W  = 27;
    localparam int SHIFT_W = 28;
    localparam int EDGE_W  = 33;
    localparam int OFF_W   = 28;
    localparam int ACC_W   = 36;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_SHIFT  = 2'd1;

    localparam logic [RATE_W-1:0]         SAMPLE_RATE_RST = 27'd2048000;
    localparam logic signed [SHIFT_W-1:0] FREQ_SHIFT_RST  = 28'sd100000;

    typedef struct packed {
        logic [TIME_W-1:0] begin_ms;
        logic [TIME_W-1:0] end_ms;
        logic [FREQ_W-1:0] frequency;
        logic [BW_W-1:0]   bandwidth;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

@@ design/twsel_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module twsel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ design/transmission_window_selector_core.sv @@
// Top level of the transmission window selector: request decode, queue walk, output rows.
// Depends on twsel_pkg and twsel_ram.
`default_nettype none

// Usage:
//   A request (clear, append or query) is taken when start is high and busy is low.
//   Clear and append give no result and leave the block idle; an append to a full queue
//   is dropped. A query walks the queue stored in twsel_ram: it drops expired head
//   entries, checks the head, forms the window, scans the active entries and ends the
//   scan, then flushes the held row; when nothing is active it ends at the head check
//   with one empty final row. The last row shows in the first cycle after busy falls.
//   The single read port of the queue RAM sets the pace: one entry per cycle.
//   Each row is shown for one cycle with o_strobe high; o_last marks the final row.
//   The receiver cannot stall, so rows are simply issued as they are found.
//   Configuration writes (i_cfg_valid, ready while idle) set sample rate and
//   frequency shift; they are taken only while the block is idle.
//   Reset (synchronous, active low) empties the queue and restores the register
//   defaults; the queue RAM is not cleared, unwritten entries are never read.

module transmission_window_selector_core #(
    parameter int QUEUE_DEPTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [1:0]                          i_action,
    input  wire logic [twsel_pkg::TIME_W-1:0]        i_begin_ms,
    input  wire logic [twsel_pkg::TIME_W-1:0]        i_end_ms,
    input  wire logic [twsel_pkg::FREQ_W-1:0]        i_frequency,
    input  wire logic [twsel_pkg::BW_W-1:0]          i_bandwidth,
    input  wire logic [twsel_pkg::TIME_W-1:0]        i_now_ms,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [twsel_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [twsel_pkg::SHIFT_W-1:0]       i_cfg_data,
    output logic                                     o_strobe,
    output logic                                     o_window_valid,
    output logic signed [twsel_pkg::EDGE_W-1:0]      o_window_left,
    output logic signed [twsel_pkg::EDGE_W-1:0]      o_window_right,
    output logic                                     o_recording_valid,
    output logic signed [twsel_pkg::OFF_W-1:0]       o_recording_offset,
    output logic                                     o_last
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int ACC_W = twsel_pkg::ACC_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DROP  = 5'b00010,
        ST_WIN   = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_FLUSH = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [twsel_pkg::TIME_W-1:0] r_now, n_now;
    logic [twsel_pkg::RATE_W-1:0] r_sample_rate;
    logic signed [twsel_pkg::SHIFT_W-1:0] r_freq_shift;

    logic signed [ACC_W-1:0] r_center, n_center;
    logic signed [ACC_W-1:0] r_left, n_left;
    logic signed [ACC_W-1:0] r_right, n_right;

    logic                    r_a_vld, n_a_vld;
    logic signed [ACC_W-1:0] r_a_lo, n_a_lo;
    logic signed [ACC_W-1:0] r_a_hi, n_a_hi;
    logic [twsel_pkg::OFF_W-1:0] r_a_off, n_a_off;

    logic                        r_pend_vld, n_pend_vld;
    logic [twsel_pkg::OFF_W-1:0] r_pend_off, n_pend_off;

    logic                              n_o_strobe, n_o_wv, n_o_rv, n_o_last;
    logic signed [twsel_pkg::EDGE_W-1:0] n_o_left, n_o_right;
    logic signed [twsel_pkg::OFF_W-1:0]  n_o_off;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    twsel_pkg::t_entry ram_wdata, ram_rdata;

    logic                    accept;
    logic                    fit;
    logic                    active;
    logic signed [ACC_W-1:0] f_ext, hb_ext, shift_ext, half_ext;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] head, input logic [CW-1:0] idx);
        logic [CW:0] s;
        s = (CW + 1)'(head) + (CW + 1)'(idx);
        if (s >= (CW + 1)'(QUEUE_DEPTH)) begin
            s = s - (CW + 1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    twsel_ram #(
        .WIDTH (twsel_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = !busy;

    assign ram_wdata.begin_ms  = i_begin_ms;
    assign ram_wdata.end_ms    = i_end_ms;
    assign ram_wdata.frequency = i_frequency;
    assign ram_wdata.bandwidth = i_bandwidth;

    assign f_ext     = $signed({{(ACC_W - twsel_pkg::FREQ_W){1'b0}}, ram_rdata.frequency});
    assign hb_ext    = $signed({{(ACC_W - twsel_pkg::BW_W + 1){1'b0}},
                                ram_rdata.bandwidth[twsel_pkg::BW_W-1:1]});
    assign shift_ext = ACC_W'(r_freq_shift);
    assign half_ext  = $signed({{(ACC_W - twsel_pkg::RATE_W + 1){1'b0}},
                                r_sample_rate[twsel_pkg::RATE_W-1:1]});

    assign fit    = r_a_vld && (r_left <= r_a_lo) && (r_a_hi <= r_right);
    assign active = (r_idx < r_count) && (ram_rdata.begin_ms <= r_now);

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_idx      = r_idx;
        n_now      = r_now;
        n_center   = r_center;
        n_left     = r_left;
        n_right    = r_right;
        n_a_vld    = 1'b0;
        n_a_lo     = r_a_lo;
        n_a_hi     = r_a_hi;
        n_a_off    = r_a_off;
        n_pend_vld = r_pend_vld;
        n_pend_off = r_pend_off;
        n_o_strobe = 1'b0;
        n_o_wv     = o_window_valid;
        n_o_rv     = o_recording_valid;
        n_o_last   = o_last;
        n_o_left   = o_window_left;
        n_o_right  = o_window_right;
        n_o_off    = o_recording_offset;
        ram_we     = 1'b0;
        ram_waddr  = slot(r_head, r_count);
        ram_raddr  = r_head;

        // fit stage: a new fit releases the previously held one as a non-final row
        if (fit) begin
            if (r_pend_vld) begin
                n_o_strobe = 1'b1;
                n_o_wv     = 1'b1;
                n_o_rv     = 1'b1;
                n_o_last   = 1'b0;
                n_o_left   = r_left[twsel_pkg::EDGE_W-1:0];
                n_o_right  = r_right[twsel_pkg::EDGE_W-1:0];
                n_o_off    = r_pend_off;
            end
            n_pend_vld = 1'b1;
            n_pend_off = r_a_off;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_action)
                        twsel_pkg::ACT_CLEAR: begin
                            n_head  = '0;
                            n_count = '0;
                        end
                        twsel_pkg::ACT_APPEND: begin
                            if (r_count < CW'(QUEUE_DEPTH)) begin
                                ram_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        twsel_pkg::ACT_QUERY: begin
                            n_now      = i_now_ms;
                            n_pend_vld = 1'b0;
                            n_state    = ST_DROP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DROP: begin
                priority if (r_count == '0 || ram_rdata.end_ms >= r_now
                             && ram_rdata.begin_ms > r_now) begin
                    n_o_strobe = 1'b1;
                    n_o_wv     = 1'b0;
                    n_o_rv     = 1'b0;
                    n_o_last   = 1'b1;
                    n_o_left   = '0;
                    n_o_right  = '0;
                    n_o_off    = '0;
                    n_state    = ST_IDLE;
                end else if (ram_rdata.end_ms < r_now) begin
                    n_head    = slot(r_head, CW'(1));
                    n_count   = r_count - CW'(1);
                    ram_raddr = slot(r_head, CW'(1));
                end else begin
                    n_center = f_ext + shift_ext;
                    n_state  = ST_WIN;
                end
            end
            ST_WIN: begin
                n_left  = r_center - half_ext;
                n_right = r_center + half_ext;
                n_idx   = '0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (active) begin
                    ram_raddr = slot(r_head, r_idx + CW'(1));
                    n_a_vld   = 1'b1;
                    n_a_lo    = f_ext - hb_ext;
                    n_a_hi    = f_ext + hb_ext;
                    n_a_off   = twsel_pkg::OFF_W'(f_ext - r_center);
                    n_idx     = r_idx + CW'(1);
                end else begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_o_strobe = 1'b1;
                n_o_wv     = 1'b1;
                n_o_rv     = r_pend_vld;
                n_o_last   = 1'b1;
                n_o_left   = r_left[twsel_pkg::EDGE_W-1:0];
                n_o_right  = r_right[twsel_pkg::EDGE_W-1:0];
                n_o_off    = r_pend_vld ? r_pend_off : '0;
                n_pend_vld = 1'b0;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_head        <= '0;
            r_count       <= '0;
            r_idx         <= '0;
            r_a_vld       <= 1'b0;
            r_pend_vld    <= 1'b0;
            o_strobe      <= 1'b0;
            r_sample_rate <= twsel_pkg::SAMPLE_RATE_RST;
            r_freq_shift  <= twsel_pkg::FREQ_SHIFT_RST;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_count    <= n_count;
            r_idx      <= n_idx;
            r_a_vld    <= n_a_vld;
            r_pend_vld <= n_pend_vld;
            o_strobe   <= n_o_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == twsel_pkg::CFG_SAMPLE_RATE) begin
                    r_sample_rate <= i_cfg_data[twsel_pkg::RATE_W-1:0];
                end else if (i_cfg_index == twsel_pkg::CFG_FREQ_SHIFT) begin
                    r_freq_shift <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_now              <= n_now;
        r_center           <= n_center;
        r_left             <= n_left;
        r_right            <= n_right;
        r_a_lo             <= n_a_lo;
        r_a_hi             <= n_a_hi;
        r_a_off            <= n_a_off;
        r_pend_off         <= n_pend_off;
        o_window_valid     <= n_o_wv;
        o_window_left      <= n_o_left;
        o_window_right     <= n_o_right;
        o_recording_valid  <= n_o_rv;
        o_recording_offset <= n_o_off;
        o_last             <= n_o_last;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_rec_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_recording_valid |-> o_window_valid)
        else $error("recording row without window");

    a_empty_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_window_valid |-> o_last && !o_recording_valid)
        else $error("empty row not final");

    a_drop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DROP && r_count != '0 && ram_rdata.end_ms < r_now
        |=> r_count == $past(r_count) - CW'(1) && r_state == ST_DROP)
        else $error("expired head not dropped");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_action == twsel_pkg::ACT_APPEND && r_count < CW'(QUEUE_DEPTH)
        |=> r_count == $past(r_count) + CW'(1))
        else $error("append lost");

endmodule

`default_nettype wire

@@ verif/transmission_window_selector_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for transmission_window_selector_core: directed and random
// clear/append/query requests with config changes, checked against an in-bench predictor.
// Depends on twsel_pkg and the core RTL.

module transmission_window_selector_core_tb;
    import twsel_pkg::*;

    localparam int QUEUE_DEPTH   = 32;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 200000;
    localparam logic [1:0]           ACT_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd2;
    localparam logic [TIME_W-1:0]    TIME_MAX   = '1;

    typedef struct {
        bit                   is_cfg;
        logic [1:0]           action;
        logic [TIME_W-1:0]    begin_ms;
        logic [TIME_W-1:0]    end_ms;
        logic [FREQ_W-1:0]    frequency;
        logic [BW_W-1:0]      bandwidth;
        logic [TIME_W-1:0]    now_ms;
        logic [CFG_IDX_W-1:0] cfg_index;
        logic [SHIFT_W-1:0]   cfg_data;
    } t_request;

    typedef struct {
        logic              window_valid;
        logic [EDGE_W-1:0] window_left;
        logic [EDGE_W-1:0] window_right;
        logic              recording_valid;
        logic [OFF_W-1:0]  recording_offset;
        logic              last;
    } t_window_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [1:0]                  i_action = ACT_CLEAR;
    logic [TIME_W-1:0]           i_begin_ms = '0;
    logic [TIME_W-1:0]           i_end_ms = '0;
    logic [FREQ_W-1:0]           i_frequency = '0;
    logic [BW_W-1:0]             i_bandwidth = '0;
    logic [TIME_W-1:0]           i_now_ms = '0;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index = CFG_SAMPLE_RATE;
    logic [SHIFT_W-1:0]          i_cfg_data = '0;
    logic                        o_strobe;
    logic                        o_window_valid;
    logic signed [EDGE_W-1:0]    o_window_left;
    logic signed [EDGE_W-1:0]    o_window_right;
    logic                        o_recording_valid;
    logic signed [OFF_W-1:0]     o_recording_offset;
    logic                        o_last;

    // schedule as the block should hold it
    logic [TIME_W-1:0]           sched_begin [QUEUE_DEPTH];
    logic [TIME_W-1:0]           sched_end [QUEUE_DEPTH];
    logic [FREQ_W-1:0]           sched_freq [QUEUE_DEPTH];
    logic [BW_W-1:0]             sched_bw [QUEUE_DEPTH];
    logic [4:0]                  sched_head = '0;
    int                          sched_count = 0;
    logic [RATE_W-1:0]           cur_rate = SAMPLE_RATE_RST;
    logic signed [SHIFT_W-1:0]   cur_shift = FREQ_SHIFT_RST;

    t_request                    requests_to_send [$];
    t_window_row                 window_rows_due [$];
    int                          items_queued = 0;
    int                          plan_rate = 2048000;
    int                          plan_shift = 100000;
    int                          errors = 0;
    int                          cycle_count = 0;
    int                          quiet_cycles = 0;
    int                          gap_left = 0;
    int                          burst_left = 0;
    bit                          req_taken = 1'b0;
    bit                          cfg_taken = 1'b0;

    transmission_window_selector_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_action(i_action),
        .i_begin_ms(i_begin_ms),
        .i_end_ms(i_end_ms),
        .i_frequency(i_frequency),
        .i_bandwidth(i_bandwidth),
        .i_now_ms(i_now_ms),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe),
        .o_window_valid(o_window_valid),
        .o_window_left(o_window_left),
        .o_window_right(o_window_right),
        .o_recording_valid(o_recording_valid),
        .o_recording_offset(o_recording_offset),
        .o_last(o_last)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [TIME_W-1:0] rand63();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[TIME_W-1:0];
    endfunction

    function automatic void predict_window_rows(t_request r);
        t_window_row row;
        logic [4:0]  slot;
        int          active;
        longint      center, half, left, right, f, hb;
        longint      fits [$];
        case (r.action)
            ACT_CLEAR: begin
                sched_head = '0;
                sched_count = 0;
            end
            ACT_APPEND: begin
                if (sched_count < QUEUE_DEPTH) begin
                    slot = sched_head + sched_count[4:0];
                    sched_begin[slot] = r.begin_ms;
                    sched_end[slot] = r.end_ms;
                    sched_freq[slot] = r.frequency;
                    sched_bw[slot] = r.bandwidth;
                    sched_count++;
                end
            end
            ACT_QUERY: begin
                while (sched_count > 0 && sched_end[sched_head] < r.now_ms) begin
                    sched_head = sched_head + 5'd1;
                    sched_count--;
                end
                active = 0;
                slot = sched_head;
                while (active < sched_count && sched_begin[slot] <= r.now_ms) begin
                    active++;
                    slot = slot + 5'd1;
                end
                row = '{1'b0, '0, '0, 1'b0, '0, 1'b1};
                if (active > 0) begin
                    center = longint'(sched_freq[sched_head]) + longint'(cur_shift);
                    half = longint'(cur_rate >> 1);
                    left = center - half;
                    right = center + half;
                    for (int i = 0; i < active; i++) begin
                        slot = sched_head + i[4:0];
                        f = longint'(sched_freq[slot]);
                        hb = longint'(sched_bw[slot] >> 1);
                        if (left <= f - hb && f + hb <= right)
                            fits.insert(fits.size(), f - center);
                    end
                    row.window_valid = 1'b1;
                    row.window_left = left[EDGE_W-1:0];
                    row.window_right = right[EDGE_W-1:0];
                end
                if (fits.size() == 0) begin
                    window_rows_due.insert(window_rows_due.size(), row);
                end else begin
                    foreach (fits[k]) begin
                        row.recording_valid = 1'b1;
                        row.recording_offset = fits[k][OFF_W-1:0];
                        row.last = (k == fits.size() - 1);
                        window_rows_due.insert(window_rows_due.size(), row);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    task automatic push_request(logic [1:0] action, logic [TIME_W-1:0] b, logic [TIME_W-1:0] e,
                                logic [FREQ_W-1:0] f, logic [31:0] bw,
                                logic [TIME_W-1:0] now);
        t_request r;
        r = '{1'b0, action, b, e, f, BW_W'(bw), now, CFG_SAMPLE_RATE, '0};
        requests_to_send.insert(requests_to_send.size(), r);
        items_queued++;
    endtask

    task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, logic [SHIFT_W-1:0] data);
        t_request r;
        r = '{1'b1, ACT_CLEAR, '0, '0, '0, '0, '0, idx, data};
        requests_to_send.insert(requests_to_send.size(), r);
    endtask

    // schedule: a random request, or optional clear, appends around one window, queries
    task automatic push_schedule();
        logic [TIME_W-1:0] t0, t, stop;
        logic [FREQ_W-1:0] f0;
        logic [31:0]       bw;
        longint            fr;
        int                kind, n;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            push_request(2'($urandom_range(0, 3)), rand63(), rand63(), $urandom, $urandom,
                         rand63());
        end else begin
            case ($urandom_range(0, 3))
                0, 1: t0 = TIME_W'($urandom_range(20, 1000));
                2: t0 = rand63();
                default: t0 = TIME_MAX - TIME_W'($urandom_range(500, 5000));
            endcase
            f0 = $urandom;
            if ($urandom_range(0, 1) == 1)
                push_request(ACT_CLEAR, rand63(), rand63(), $urandom, $urandom, rand63());
            n = $urandom_range(1, 8);
            t = t0;
            for (int k = 0; k < n; k++) begin
                if (kind == 9)
                    t = t - TIME_W'($urandom_range(0, 20));
                else
                    t = t + TIME_W'($urandom_range(0, 20));
                fr = (k == 0) ? longint'(f0) :
                     longint'(f0) + longint'(plan_shift) +
                     longint'($urandom_range(0, plan_rate + 2000)) - longint'((plan_rate + 2000) / 2);
                bw = ($urandom_range(0, 3) == 0) ? $urandom :
                     $urandom_range(0, plan_rate / 8);
                stop = (kind == 9 && $urandom_range(0, 1) == 1) ?
                       t - TIME_W'($urandom_range(1, 30)) :
                       t + TIME_W'($urandom_range(0, 60));
                push_request(ACT_APPEND, t, stop, fr[FREQ_W-1:0], bw, rand63());
            end
            n = $urandom_range(1, 3);
            for (int q = 0; q < n; q++)
                push_request(ACT_QUERY, rand63(), rand63(), $urandom, $urandom,
                             t0 + TIME_W'($urandom_range(0, 200)));
        end
    endtask

    // driver: requests and config writes change on the falling edge
    always @(negedge i_clk) begin
        t_request nxt;
        logic     nx_start, nx_cfg;
        nx_start = start;
        nx_cfg = i_cfg_valid;
        if (i_rst_n) begin
            if (start && req_taken)
                nx_start = 1'b0;
            if (i_cfg_valid && cfg_taken)
                nx_cfg = 1'b0;
            if (!nx_start && !nx_cfg && requests_to_send.size() > 0) begin
                if (requests_to_send[0].is_cfg) begin
                    if (window_rows_due.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
                        nxt = requests_to_send[0];
                        requests_to_send.delete(0);
                        i_cfg_index <= nxt.cfg_index;
                        i_cfg_data <= nxt.cfg_data;
                        nx_cfg = 1'b1;
                    end
                end else if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    nxt = requests_to_send[0];
                    requests_to_send.delete(0);
                    i_action <= nxt.action;
                    i_begin_ms <= nxt.begin_ms;
                    i_end_ms <= nxt.end_ms;
                    i_frequency <= nxt.frequency;
                    i_bandwidth <= nxt.bandwidth;
                    i_now_ms <= nxt.now_ms;
                    nx_start = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30) :
                                     $urandom_range(0, 6);
                    end
                end
            end
        end
        start <= nx_start;
        i_cfg_valid <= nx_cfg;
    end

    // monitor: handshakes, predictor update and row checks on the rising edge
    always @(posedge i_clk) begin
        t_window_row want;
        t_request    got_req;
        req_taken = i_rst_n && start && !busy;
        cfg_taken = i_rst_n && i_cfg_valid && o_cfg_ready;
        if (!i_rst_n || busy || start || i_cfg_valid || o_strobe)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (i_rst_n && o_strobe) begin
            if (window_rows_due.size() == 0) begin
                $error("result row with no request pending");
                errors++;
            end else begin
                want = window_rows_due[0];
                window_rows_due.delete(0);
                check_field("window_valid", want.window_valid, o_window_valid);
                check_field("window_left", want.window_left, $unsigned(o_window_left));
                check_field("window_right", want.window_right, $unsigned(o_window_right));
                check_field("recording_valid", want.recording_valid, o_recording_valid);
                check_field("recording_offset", want.recording_offset,
                            $unsigned(o_recording_offset));
                check_field("last", want.last, o_last);
            end
        end
        if (cfg_taken) begin
            case (i_cfg_index)
                CFG_SAMPLE_RATE: cur_rate = i_cfg_data[RATE_W-1:0];
                CFG_FREQ_SHIFT:  cur_shift = i_cfg_data;
                default: ;
            endcase
        end
        if (req_taken) begin
            got_req = '{1'b0, i_action, i_begin_ms, i_end_ms, i_frequency, i_bandwidth,
                        i_now_ms, CFG_SAMPLE_RATE, '0};
            predict_window_rows(got_req);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int phase_rate [5];
        int phase_shift [5];
        int target;
        longint fr;
        phase_rate = '{0, 100000000, 100000000, 0, 2048000};
        phase_shift = '{-100000000, 100000000, -100000000, 0, 0};
        phase_rate[3] = $urandom_range(0, 100000000);
        phase_shift[3] = int'($urandom_range(0, 200000000)) - 100000000;

        // directed part at reset settings: center 1100000, edges 76000 and 2124000
        push_request(ACT_QUERY, rand63(), rand63(), $urandom, $urandom, '0);
        push_request(ACT_UNUSED, rand63(), rand63(), $urandom, $urandom, rand63());
        push_request(ACT_APPEND, '0, TIME_MAX, 32'd1000000, '0, rand63());
        push_request(ACT_APPEND, '0, TIME_MAX, 32'd2124000, '0, rand63());
        push_request(ACT_APPEND, '0, TIME_MAX, 32'd76000, 32'd2, rand63());
        push_request(ACT_APPEND, '0, TIME_MAX, 32'd2000000, 32'd248001, rand63());
        push_request(ACT_APPEND, '0, TIME_MAX, 32'd2000000, 32'd248003, rand63());
        push_request(ACT_APPEND, 63'd5, TIME_MAX, 32'd1000000, '0, rand63());
        push_request(ACT_QUERY, rand63(), rand63(), $urandom, $urandom, '0);
        push_request(ACT_APPEND, TIME_MAX, TIME_MAX, '1, '1, rand63());
        push_request(ACT_QUERY, rand63(), rand63(), $urandom, $urandom, TIME_MAX);
        push_request(ACT_CLEAR, rand63(), rand63(), $urandom, $urandom, rand63());
        push_request(ACT_APPEND, '0, '0, '0, '0, rand63());
        push_request(ACT_QUERY, rand63(), rand63(), $urandom, $urandom, 63'd1);
        push_request(ACT_APPEND, '0, 63'd100, 32'd4000000000, 32'd100000000, rand63());
        push_request(ACT_QUERY, rand63(), rand63(), $urandom, $urandom, 63'd50);
        push_request(ACT_APPEND, '0, 63'd100, 32'd4000100000, 32'd2048000, rand63());
        push_request(ACT_QUERY, rand63(), rand63(), $urandom, $urandom, 63'd100);
        push_request(ACT_QUERY, rand63(), rand63(), $urandom, $urandom, 63'd101);
        push_request(ACT_CLEAR, rand63(), rand63(), $urandom, $urandom, rand63());

        for (int p = 0; p < 5; p++) begin
            push_cfg(CFG_SAMPLE_RATE, SHIFT_W'(phase_rate[p]));
            push_cfg(CFG_FREQ_SHIFT, SHIFT_W'(phase_shift[p]));
            if (p == 3)
                push_cfg(CFG_UNUSED, SHIFT_W'($urandom));
            plan_rate = phase_rate[p];
            plan_shift = phase_shift[p];
            if (p == 1) begin
                // overfill the queue, then query it whole
                push_request(ACT_CLEAR, rand63(), rand63(), $urandom, $urandom, rand63());
                for (int k = 0; k < QUEUE_DEPTH + 2; k++) begin
                    fr = 64'd1000000000 + longint'(plan_shift) +
                         longint'($urandom_range(0, 80000000)) - 64'd40000000;
                    push_request(ACT_APPEND, TIME_W'(k), TIME_MAX, fr[FREQ_W-1:0],
                                 $urandom_range(0, 4000000), rand63());
                end
                push_request(ACT_QUERY, rand63(), rand63(), $urandom, $urandom, 63'd40);
                push_request(ACT_QUERY, rand63(), rand63(), $urandom, $urandom, '0);
            end
            target = items_queued + 12;
            while (items_queued < target)
                push_schedule();
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_to_send.size() != 0 || start || i_cfg_valid)
            @(posedge i_clk);
        while (window_rows_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && window_rows_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
